// ===== design/qmm_pkg.sv =====
// shared widths, register codes, reset values and coefficient bundle
// for the quadrotor motor mixer; no dependencies
package qmm_pkg;

    localparam int GAIN_W     = 32;
    localparam int EFF_W      = 32;
    localparam int COEF_W     = 48;
    localparam int RATE_W     = 12;
    localparam int CNT_W      = 16;
    localparam int NMOT       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // clamped motor thrust, units of 2^-32, always below 2^63
    localparam int THR_W      = 63;

    // square root: one result bit per stage over a 114 bit radicand
    localparam int SQRT_STEPS = 57;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int REM_W      = SQRT_STEPS + 2;

    // count division: 17 quotient bits, anything larger saturates
    localparam int DIV_STEPS  = 17;
    localparam int NUM_W      = 85;
    localparam int DEN_W      = 70;

    localparam int FRONT_LAT  = 3;
    localparam int MOTOR_LAT  = 4 + SQRT_STEPS + 4 + DIV_STEPS + 1;

    // pulse scale 0.004095 as 8190 / 2000000, half of the divisor added for rounding
    localparam int unsigned PWM_SCALE = 8190;
    localparam int unsigned DD_FULL   = 2000000;
    localparam int unsigned DD_HALF   = 1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_GAIN  = 4'd0,
        CFG_PITCH_GAIN = 4'd1,
        CFG_YAW_GAIN   = 4'd2,
        CFG_QUAD_COEF  = 4'd3,
        CFG_LIN_COEF   = 4'd4,
        CFG_CONST_COEF = 4'd5,
        CFG_PWM_RATE   = 4'd6,
        CFG_MAX_COUNT  = 4'd7
    } qmm_cfg_idx_t;

    localparam logic [GAIN_W-1:0] ROLL_GAIN_RST  = 32'd407391;
    localparam logic [GAIN_W-1:0] PITCH_GAIN_RST = 32'd407391;
    localparam logic [GAIN_W-1:0] YAW_GAIN_RST   = 32'd327680;
    localparam logic [COEF_W-1:0] QUAD_COEF_RST  = 48'd35837;
    localparam logic [COEF_W-1:0] LIN_COEF_RST   = -48'sd67400922;
    localparam logic [COEF_W-1:0] CONST_COEF_RST = 48'd31219258281;
    localparam logic [RATE_W-1:0] PWM_RATE_RST   = 12'd300;
    localparam logic [CNT_W-1:0]  MAX_COUNT_RST  = 16'd2400;

    // subtract flags per motor: bit 2 roll, bit 1 pitch, bit 0 yaw
    localparam logic [2:0] MIX_NEG [NMOT] = '{3'b111, 3'b010, 3'b001, 3'b100};

    typedef struct packed {
        logic [COEF_W-1:0]        a_mag;
        logic                     a_neg;
        logic                     a_zero;
        logic [COEF_W-1:0]        lin;
        logic [COEF_W-1:0]        cst;
        logic [2*COEF_W-2:0]      b_sq;
        logic [RATE_W-1:0]        rate;
        logic [DEN_W-1:0]         dd_half;
        logic [DEN_W-1:0]         dd;
        logic [CNT_W-1:0]         lim;
    } qmm_coef_t;

endpackage

// ===== design/qmm_motor.sv =====
// one motor: inverts the quadratic thrust model and scales to a pwm count
// depends on qmm_pkg; every register advances only while en is high
module qmm_motor (
    input  logic                      clk,
    input  logic                      en,
    input  qmm_pkg::qmm_coef_t        coef,
    input  logic [qmm_pkg::THR_W-1:0] thrust,
    output logic [qmm_pkg::CNT_W-1:0] count,
    output logic                      clip
);
    import qmm_pkg::*;

    // c - t and its magnitude
    logic [64:0] diff;
    logic        vneg_reg;
    logic [63:0] mv_reg;

    assign diff = {{(65-COEF_W){coef.cst[COEF_W-1]}}, coef.cst} - {2'b00, thrust};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vneg_reg <= diff[64];
            mv_reg   <= diff[64] ? (~diff[63:0] + 64'd1) : diff[63:0];
        end
    end

    // |a| * |c - t| as four partial products
    logic [55:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic        sgn2_reg, sgn3_reg;
    logic [111:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= 56'(coef.a_mag[23:0])  * 56'(mv_reg[31:0]);
            pp_lh_reg <= 56'(coef.a_mag[23:0])  * 56'(mv_reg[63:32]);
            pp_hl_reg <= 56'(coef.a_mag[47:24]) * 56'(mv_reg[31:0]);
            pp_hh_reg <= 56'(coef.a_mag[47:24]) * 56'(mv_reg[63:32]);
            sgn2_reg  <= vneg_reg ^ coef.a_neg;
            prod_reg  <= 112'(pp_ll_reg) + (112'(pp_lh_reg) << 32)
                       + (112'(pp_hl_reg) << 24) + (112'(pp_hh_reg) << 56);
            sgn3_reg  <= sgn2_reg;
        end
    end

    // discriminant b^2 - 4a(c - t)
    logic [115:0] four_ac;
    logic [115:0] bsq_ext;
    logic [115:0] disc;

    assign four_ac = {2'b00, prod_reg, 2'b00};
    assign bsq_ext = 116'(coef.b_sq);
    assign disc    = sgn3_reg ? (bsq_ext + four_ac) : (bsq_ext - four_ac);

    logic [RAD_W-1:0]      rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]      rem_reg  [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] root_reg [SQRT_STEPS+1];
    logic                  dneg_reg [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= disc[RAD_W-1:0];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            dneg_reg[0] <= disc[115];
        end
    end

    // restoring square root, one root bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic             ge;
        logic [REM_W+1:0] sub;

        assign cur   = {rem_reg[j], rad_reg[j][RAD_W-1 -: 2]};
        assign trial = {2'b00, root_reg[j], 2'b01};
        assign ge    = (cur >= trial);
        assign sub   = cur - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j+1] <= {root_reg[j][SQRT_STEPS-2:0], ge};
                dneg_reg[j+1] <= dneg_reg[j];
            end
        end

        if (j < SQRT_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? sub[REM_W-1:0] : cur[REM_W-1:0];
                    rad_reg[j+1] <= {rad_reg[j][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    // numerator root - b, sign checks against a
    logic [65:0] num;
    logic        num_neg;
    logic [57:0] nmag_reg;
    logic        rz1_reg, rz2_reg, rz3_reg;
    logic [DEN_W-1:0] pr_reg;
    logic [NUM_W-1:0] x_reg;

    assign num     = {{(66-SQRT_STEPS){1'b0}}, root_reg[SQRT_STEPS]}
                   - {{(66-COEF_W){coef.lin[COEF_W-1]}}, coef.lin};
    assign num_neg = num[65];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= num_neg ? (~num[57:0] + 58'd1) : num[57:0];
            rz1_reg  <= dneg_reg[SQRT_STEPS] || (num == '0) || (num_neg != coef.a_neg);
            pr_reg   <= DEN_W'(nmag_reg) * DEN_W'(coef.rate);
            rz2_reg  <= rz1_reg;
            x_reg    <= NUM_W'(pr_reg) * NUM_W'(PWM_SCALE) + NUM_W'(coef.dd_half);
            rz3_reg  <= rz2_reg;
        end
    end

    // quotient x / dd, with a flag when it needs more than DIV_STEPS bits
    logic [NUM_W-1:0]     drem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg    [DIV_STEPS+1];
    logic                 rz_reg   [DIV_STEPS+1];
    logic                 ovf_reg  [DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= x_reg;
            q_reg[0]    <= '0;
            rz_reg[0]   <= rz3_reg;
            ovf_reg[0]  <= ({2'b00, x_reg} >= {coef.dd, {DIV_STEPS{1'b0}}});
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - i;
        logic [NUM_W+2:0] dsh;
        logic [NUM_W+2:0] rext;
        logic             ge;
        logic [NUM_W+2:0] sub;

        assign dsh  = (NUM_W+3)'(coef.dd) << B;
        assign rext = (NUM_W+3)'(drem_reg[i]);
        assign ge   = (rext >= dsh);
        assign sub  = rext - dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i+1]   <= q_reg[i] | (DIV_STEPS'(ge) << B);
                rz_reg[i+1]  <= rz_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end

        if (i < DIV_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[i+1] <= ge ? sub[NUM_W-1:0] : drem_reg[i];
                end
            end
        end
    end

    // saturation and result
    logic                 big;
    logic [CNT_W-1:0]     count_reg;
    logic                 clip_reg;

    assign big = ovf_reg[DIV_STEPS] || (q_reg[DIV_STEPS] > {1'b0, coef.lim});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (coef.a_zero)
            begin
                count_reg <= coef.lim;
                clip_reg  <= 1'b1;
            end
            else if (rz_reg[DIV_STEPS])
            begin
                count_reg <= '0;
                clip_reg  <= 1'b0;
            end
            else if (big)
            begin
                count_reg <= coef.lim;
                clip_reg  <= 1'b1;
            end
            else
            begin
                count_reg <= q_reg[DIV_STEPS][CNT_W-1:0];
                clip_reg  <= 1'b0;
            end
        end
    end

    assign count = count_reg;
    assign clip  = clip_reg;

endmodule

// ===== design/quad_motor_mixer_thrust_to_pwm.sv =====
// top level of the quadrotor x mixer: registers, effort mixing, four motor units
// depends on qmm_pkg and qmm_motor
//
// Takes one request of thrust and roll/pitch/yaw efforts per cycle while
// effort_stall is low and returns one set of four pwm counts and a clip mask
// per request, in order. The pipeline holds three front stages (input, gain
// products, mixing), 83 per-motor stages of which the square root takes 57
// (one root bit per stage) and the count division 17 (one quotient bit per
// stage), then the output register. Sustained rate is one request per clock
// while effort_stall stays low. A stall on the result side freezes the
// pipeline only when a finished result is queued behind the waiting one;
// registers must be written with no request in flight.
module quad_motor_mixer_thrust_to_pwm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qmm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           effort_valid,
    output logic                           effort_stall,
    input  logic signed [31:0]             total_thrust,
    input  logic signed [31:0]             roll_effort,
    input  logic signed [31:0]             pitch_effort,
    input  logic signed [31:0]             yaw_effort,
    output logic                           count_valid,
    input  logic                           count_stall,
    output logic [15:0]                    motor_one,
    output logic [15:0]                    motor_two,
    output logic [15:0]                    motor_three,
    output logic [15:0]                    motor_four,
    output logic [3:0]                     clipped_mask
);
    import qmm_pkg::*;

    localparam int PIPE = FRONT_LAT + MOTOR_LAT;

    // configuration registers
    logic [GAIN_W-1:0] roll_gain_reg, pitch_gain_reg, yaw_gain_reg;
    logic [COEF_W-1:0] quad_coef_reg, lin_coef_reg, const_coef_reg;
    logic [RATE_W-1:0] pwm_rate_reg;
    logic [CNT_W-1:0]  max_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_gain_reg  <= ROLL_GAIN_RST;
            pitch_gain_reg <= PITCH_GAIN_RST;
            yaw_gain_reg   <= YAW_GAIN_RST;
            quad_coef_reg  <= QUAD_COEF_RST;
            lin_coef_reg   <= LIN_COEF_RST;
            const_coef_reg <= CONST_COEF_RST;
            pwm_rate_reg   <= PWM_RATE_RST;
            max_count_reg  <= MAX_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (qmm_cfg_idx_t'(cfg_index))
                CFG_ROLL_GAIN:  roll_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_PITCH_GAIN: pitch_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_YAW_GAIN:   yaw_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_QUAD_COEF:  quad_coef_reg  <= cfg_data[COEF_W-1:0];
                CFG_LIN_COEF:   lin_coef_reg   <= cfg_data[COEF_W-1:0];
                CFG_CONST_COEF: const_coef_reg <= cfg_data[COEF_W-1:0];
                CFG_PWM_RATE:   pwm_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_MAX_COUNT:  max_count_reg  <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // coefficient terms derived from the registers, settled long before use
    logic [COEF_W-1:0]   ma_reg, bm_reg;
    logic                a_neg_reg, a_zero_reg;
    logic [2*24-1:0]     b_ll_reg, b_lh_reg, b_hh_reg;
    logic [2*COEF_W-2:0] b_sq_reg;
    logic [DEN_W-1:0]    dd_reg, dd_half_reg;
    qmm_coef_t           coef;

    always_ff @(posedge clk)
    begin
        ma_reg      <= quad_coef_reg[COEF_W-1] ? (~quad_coef_reg + 48'd1) : quad_coef_reg;
        bm_reg      <= lin_coef_reg[COEF_W-1] ? (~lin_coef_reg + 48'd1) : lin_coef_reg;
        a_neg_reg   <= quad_coef_reg[COEF_W-1];
        a_zero_reg  <= (quad_coef_reg == '0);
        b_ll_reg    <= 48'(bm_reg[23:0])  * 48'(bm_reg[23:0]);
        b_lh_reg    <= 48'(bm_reg[23:0])  * 48'(bm_reg[47:24]);
        b_hh_reg    <= 48'(bm_reg[47:24]) * 48'(bm_reg[47:24]);
        dd_reg      <= DEN_W'({ma_reg, 1'b0}) * DEN_W'(DD_FULL);
        dd_half_reg <= DEN_W'({ma_reg, 1'b0}) * DEN_W'(DD_HALF);
        b_sq_reg    <= (2*COEF_W-1)'(b_ll_reg) + ((2*COEF_W-1)'(b_lh_reg) << 25)
                     + ((2*COEF_W-1)'(b_hh_reg) << 48);
    end

    assign coef = '{a_mag:   ma_reg,
                    a_neg:   a_neg_reg,
                    a_zero:  a_zero_reg,
                    lin:     lin_coef_reg,
                    cst:     const_coef_reg,
                    b_sq:    b_sq_reg,
                    rate:    pwm_rate_reg,
                    dd_half: dd_half_reg,
                    dd:      dd_reg,
                    lim:     max_count_reg};

    // flow control: hold everything only when the last stage has nowhere to go
    logic [PIPE-1:0] vld_reg;
    logic            count_valid_reg;
    logic            load;
    logic            en;

    assign load         = !count_valid_reg || !count_stall;
    assign en           = load || !vld_reg[PIPE-1];
    assign effort_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE-2:0], effort_valid};
        end
    end

    // front stages: capture, gain products, mixing per motor
    logic signed [EFF_W-1:0] tot_reg, roll_reg, pitch_reg, yaw_reg;
    logic signed [47:0]      base_reg;
    logic signed [63:0]      p_reg [3];
    logic [THR_W-1:0]        thr_reg [NMOT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tot_reg   <= total_thrust;
            roll_reg  <= roll_effort;
            pitch_reg <= pitch_effort;
            yaw_reg   <= yaw_effort;
            base_reg  <= {tot_reg, 16'h0000};
            p_reg[0]  <= 64'(signed'(roll_gain_reg))  * 64'(roll_reg);
            p_reg[1]  <= 64'(signed'(pitch_gain_reg)) * 64'(pitch_reg);
            p_reg[2]  <= 64'(signed'(yaw_gain_reg))   * 64'(yaw_reg);
        end
    end

    logic [CNT_W-1:0] cnt [NMOT];
    logic [NMOT-1:0]  clp;

    for (genvar m = 0; m < NMOT; m++)
    begin : g_motor
        logic signed [65:0] acc;

        always_comb
        begin
            acc = 66'(base_reg);
            acc = MIX_NEG[m][2] ? acc - 66'(p_reg[0]) : acc + 66'(p_reg[0]);
            acc = MIX_NEG[m][1] ? acc - 66'(p_reg[1]) : acc + 66'(p_reg[1]);
            acc = MIX_NEG[m][0] ? acc - 66'(p_reg[2]) : acc + 66'(p_reg[2]);
        end

        // floor of the sum over four, negative thrust clamped to zero
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                thr_reg[m] <= acc[65] ? '0 : acc[64:2];
            end
        end

        qmm_motor u_motor (
            .clk    (clk),
            .en     (en),
            .coef   (coef),
            .thrust (thr_reg[m]),
            .count  (cnt[m]),
            .clip   (clp[m])
        );
    end

    // output register
    logic [CNT_W-1:0] motor_one_reg, motor_two_reg, motor_three_reg, motor_four_reg;
    logic [NMOT-1:0]  clipped_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            count_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && vld_reg[PIPE-1])
        begin
            motor_one_reg    <= cnt[0];
            motor_two_reg    <= cnt[1];
            motor_three_reg  <= cnt[2];
            motor_four_reg   <= cnt[3];
            clipped_mask_reg <= clp;
        end
    end

    assign count_valid  = count_valid_reg;
    assign motor_one    = motor_one_reg;
    assign motor_two    = motor_two_reg;
    assign motor_three  = motor_three_reg;
    assign motor_four   = motor_four_reg;
    assign clipped_mask = clipped_mask_reg;

    // a clipped motor shows exactly the limit
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> (!clipped_mask[0] || motor_one == max_count_reg)
                     && (!clipped_mask[1] || motor_two == max_count_reg)
                     && (!clipped_mask[2] || motor_three == max_count_reg)
                     && (!clipped_mask[3] || motor_four == max_count_reg))
        else $error("clipped motor count differs from max_count");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> motor_one <= max_count_reg && motor_two <= max_count_reg
                     && motor_three <= max_count_reg && motor_four <= max_count_reg)
        else $error("motor count above max_count");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && count_stall && vld_reg[PIPE-1] |=> $stable(vld_reg))
        else $error("pipeline moved while its last result was blocked");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(count_valid) |-> $past(vld_reg[PIPE-1]))
        else $error("result appeared without a finished pipeline entry");

endmodule

// ===== sim/tb.sv =====
// testbench for quad_motor_mixer_thrust_to_pwm: mixes efforts and checks pwm counts
// against an exact wide-integer model of the mixer and thrust inversion
// depends on qmm_pkg and the design sources
`timescale 1ns / 1ps

module tb;
    import qmm_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD = 400;
    localparam int RAND_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 95;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

    typedef enum int { PRE_NONE, PRE_DEFAULT, PRE_ZERO_QUAD, PRE_ZERO_RATE,
                       PRE_NEG_DISC } preset_t;

    typedef struct packed {
        logic [NMOT-1:0][CNT_W-1:0] cnt;
        logic [NMOT-1:0]            clip;
    } counts_t;

    typedef struct {
        preset_t            pre;
        logic signed [31:0] tt, r, p, y;
        bit                 typed;
        counts_t            exp_counts;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic effort_valid;
    logic effort_stall;
    logic signed [31:0] total_thrust, roll_effort, pitch_effort, yaw_effort;
    logic count_valid;
    logic count_stall;
    logic [15:0] motor_one, motor_two, motor_three, motor_four;
    logic [3:0] clipped_mask;

    quad_motor_mixer_thrust_to_pwm u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .effort_valid(effort_valid), .effort_stall(effort_stall),
        .total_thrust(total_thrust), .roll_effort(roll_effort),
        .pitch_effort(pitch_effort), .yaw_effort(yaw_effort),
        .count_valid(count_valid), .count_stall(count_stall),
        .motor_one(motor_one), .motor_two(motor_two),
        .motor_three(motor_three), .motor_four(motor_four),
        .clipped_mask(clipped_mask)
    );

    // mirror of the register file
    logic signed [GAIN_W-1:0] roll_g, pitch_g, yaw_g;
    logic signed [COEF_W-1:0] quad_c, lin_c, const_c;
    logic [RATE_W-1:0] rate_hz;
    logic [CNT_W-1:0] lim;

    counts_t pending_counts[$];
    row_t    directed_rows[$];
    int      mismatches = 0;
    longint  cycles = 0;
    bit      effort_taken = 0;
    bit      count_taken = 0;
    bit      quiet = 0;
    bit      long_hold = 0;
    bit      cur_typed = 0;
    counts_t cur_counts;

    initial
    begin
        clk = 0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] thrust_to_count(input logic signed [255:0] t,
                                                         output logic clip);
        logic signed [255:0] a, b, c, disc, root, cand, num, nmag, den, x, two_dd;
        a = quad_c;
        b = lin_c;
        c = const_c;
        clip = 0;
        if (a == 0)
        begin
            clip = 1;
            return lim;
        end
        disc = b * b - 4 * a * (c - t);
        if (disc < 0)
            return 0;
        root = 0;
        for (int i = SQRT_STEPS - 1; i >= 0; i--)
        begin
            cand = root | (256'sd1 <<< i);
            if (cand * cand <= disc)
                root = cand;
        end
        num = root - b;
        if (num == 0 || ((num < 0) != (a < 0)))
            return 0;
        nmag = (num < 0) ? -num : num;
        den = 2 * ((a < 0) ? -a : a);
        x = nmag * PWM_SCALE * $signed({1'b0, rate_hz}) + den * DD_HALF;
        two_dd = den * DD_FULL;
        if (two_dd * ($signed({1'b0, lim}) + 1) <= x)
        begin
            clip = 1;
            return lim;
        end
        x = x / two_dd;
        return x[CNT_W-1:0];
    endfunction

    function automatic counts_t mix_to_counts(input logic signed [31:0] tt, r, p, y);
        logic signed [255:0] base, prod_r, prod_p, prod_y, sum;
        counts_t res;
        logic clip;
        base = tt;
        base = base * 65536;
        prod_r = roll_g;
        prod_r = prod_r * r;
        prod_p = pitch_g;
        prod_p = prod_p * p;
        prod_y = yaw_g;
        prod_y = prod_y * y;
        for (int m = 0; m < NMOT; m++)
        begin
            sum = base + (MIX_NEG[m][2] ? -prod_r : prod_r)
                       + (MIX_NEG[m][1] ? -prod_p : prod_p)
                       + (MIX_NEG[m][0] ? -prod_y : prod_y);
            sum = sum >>> 2;
            if (sum < 0)
                sum = 0;
            res.cnt[m] = thrust_to_count(sum, clip);
            res.clip[m] = clip;
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // sampling at the rising edge, before the design's registers update
    always @(posedge clk)
    begin
        counts_t want;
        cycles++;
        effort_taken = effort_valid && !effort_stall;
        count_taken = count_valid && !count_stall;
        if (effort_taken)
            pending_counts.push_back(cur_typed ? cur_counts :
                mix_to_counts(total_thrust, roll_effort, pitch_effort, yaw_effort));
        if (count_taken)
        begin
            if (pending_counts.size() == 0)
            begin
                report("unexpected result", motor_one, 16'd0);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (motor_one !== want.cnt[0]) report("motor_one", motor_one, want.cnt[0]);
                if (motor_two !== want.cnt[1]) report("motor_two", motor_two, want.cnt[1]);
                if (motor_three !== want.cnt[2])
                    report("motor_three", motor_three, want.cnt[2]);
                if (motor_four !== want.cnt[3]) report("motor_four", motor_four, want.cnt[3]);
                if (clipped_mask !== want.clip)
                    report("clipped_mask", {12'd0, clipped_mask}, {12'd0, want.clip});
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls per result, plus one long hold-off on request
    initial
    begin
        int w;
        count_stall <= 0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                count_stall <= 1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 0;
                count_stall <= 0;
            end
            else
            begin
                w = quiet ? 0 : $urandom_range(0, 18);
                if (w > 0)
                begin
                    count_stall <= 1;
                    repeat (w) @(negedge clk);
                    count_stall <= 0;
                end
            end
            do @(negedge clk); while (!count_taken);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 0;
        @(negedge clk);
        case (idx)
            CFG_ROLL_GAIN:  roll_g = val[GAIN_W-1:0];
            CFG_PITCH_GAIN: pitch_g = val[GAIN_W-1:0];
            CFG_YAW_GAIN:   yaw_g = val[GAIN_W-1:0];
            CFG_QUAD_COEF:  quad_c = val[COEF_W-1:0];
            CFG_LIN_COEF:   lin_c = val[COEF_W-1:0];
            CFG_CONST_COEF: const_c = val[COEF_W-1:0];
            CFG_PWM_RATE:   rate_hz = val[RATE_W-1:0];
            CFG_MAX_COUNT:  lim = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every request has come back and the pipeline is empty
    task automatic drain();
        effort_valid <= 0;
        while (pending_counts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_defaults();
        write_reg(CFG_ROLL_GAIN, 48'(ROLL_GAIN_RST));
        write_reg(CFG_PITCH_GAIN, 48'(PITCH_GAIN_RST));
        write_reg(CFG_YAW_GAIN, 48'(YAW_GAIN_RST));
        write_reg(CFG_QUAD_COEF, QUAD_COEF_RST);
        write_reg(CFG_LIN_COEF, LIN_COEF_RST);
        write_reg(CFG_CONST_COEF, CONST_COEF_RST);
        write_reg(CFG_PWM_RATE, 48'(PWM_RATE_RST));
        write_reg(CFG_MAX_COUNT, 48'(MAX_COUNT_RST));
    endtask

    task automatic send_effort(input logic signed [31:0] tt, r, p, y,
                               input bit typed, input counts_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            effort_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        effort_valid <= 1;
        total_thrust <= tt;
        roll_effort <= r;
        pitch_effort <= p;
        yaw_effort <= y;
        cur_typed = typed;
        cur_counts = want;
        do @(negedge clk); while (!effort_taken);
    endtask

    task automatic add_row(input preset_t pre, input logic signed [31:0] tt, r, p, y,
                           input bit typed = 0, input logic [15:0] c = 0,
                           input logic [3:0] clip = 0);
        row_t row;
        row.pre = pre;
        row.tt = tt;
        row.r = r;
        row.p = p;
        row.y = y;
        row.typed = typed;
        row.exp_counts = {c, c, c, c, clip};
        directed_rows.push_back(row);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return CFG_DATA_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        endcase
    endfunction

    task automatic random_config(input int phase);
        logic signed [COEF_W-1:0] q, l, k;
        write_reg(CFG_ROLL_GAIN, phase == 1 ? 48'h7fffffff :
                  phase == 2 ? 48'h80000000 : 48'($signed($urandom_range(0, 1 << 20)) - 300000));
        write_reg(CFG_PITCH_GAIN, phase == 2 ? 48'h7fffffff :
                  phase == 3 ? rand48() : 48'($signed($urandom_range(0, 1 << 20)) - 300000));
        write_reg(CFG_YAW_GAIN, phase == 1 ? 48'h80000000 :
                  48'($signed($urandom_range(0, 1 << 20)) - 400000));
        q = $signed(QUAD_COEF_RST) + $signed($urandom_range(0, 20000)) - 10000;
        l = $signed(LIN_COEF_RST) + $signed($urandom_range(0, 20000000)) - 10000000;
        k = $signed(CONST_COEF_RST) + $signed($urandom_range(0, 1 << 30)) - (1 << 29);
        case (phase % 4)
            1:
            begin
                q = -q;
                l = -l;
            end
            2:
            begin
                q = rand48();
                l = rand48();
                k = rand48();
            end
            3:
                if (phase > 4)
                begin
                    q = 48'h7fffffffffff;
                    l = 48'h800000000000;
                    k = 48'h800000000000;
                end
            default: ;
        endcase
        write_reg(CFG_QUAD_COEF, q);
        write_reg(CFG_LIN_COEF, l);
        write_reg(CFG_CONST_COEF, k);
        write_reg(CFG_PWM_RATE, phase == 3 ? 48'd4095 : phase == 5 ? 48'd1 :
                  phase == 7 ? rand48() : 48'($urandom_range(0, 4095)));
        write_reg(CFG_MAX_COUNT, phase == 4 ? 48'd65535 : phase == 6 ? 48'd0 :
                  phase == 8 ? rand48() : 48'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        counts_t none;
        none = '0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        effort_valid = 0;
        total_thrust = 0;
        roll_effort = 0;
        pitch_effort = 0;
        yaw_effort = 0;
        roll_g = ROLL_GAIN_RST;
        pitch_g = PITCH_GAIN_RST;
        yaw_g = YAW_GAIN_RST;
        quad_c = QUAD_COEF_RST;
        lin_c = LIN_COEF_RST;
        const_c = CONST_COEF_RST;
        rate_hz = PWM_RATE_RST;
        lim = MAX_COUNT_RST;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // settings after reset, then corner settings with known counts
        add_row(PRE_NONE, 0, 0, 0, 0);
        add_row(PRE_NONE, 15 << 16, 0, 0, 0);
        add_row(PRE_NONE, 20 << 16, 1 << 16, -(1 << 16), 1 << 15);
        add_row(PRE_NONE, 32'sh7fffffff, 0, 0, 0);
        add_row(PRE_NONE, 32'sh80000000, 0, 0, 0);
        add_row(PRE_NONE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_row(PRE_NONE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_row(PRE_NONE, 10 << 16, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add_row(PRE_NONE, 10 << 16, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_row(PRE_NONE, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        add_row(PRE_NONE, 12 << 16, 3 << 16, 2 << 16, -(4 << 16));
        add_row(PRE_ZERO_QUAD, 10 << 16, 0, 0, 0, 1, MAX_COUNT_RST, 4'hf);
        add_row(PRE_NONE, 32'sh80000000, 32'sh7fffffff, 0, 0, 1, MAX_COUNT_RST, 4'hf);
        add_row(PRE_ZERO_RATE, 32'sh7fffffff, 0, 0, 0, 1, 0, 4'h0);
        add_row(PRE_NONE, 20 << 16, 5 << 16, -(5 << 16), 5 << 16, 1, 0, 4'h0);
        add_row(PRE_NEG_DISC, 0, 0, 0, 0, 1, 0, 4'h0);
        add_row(PRE_NONE, 1 << 16, 0, 0, 0, 1, 0, 4'h0);
        add_row(PRE_DEFAULT, 20 << 16, 0, 0, 0);
        add_row(PRE_NONE, 40 << 16, -(2 << 16), 3 << 16, 1 << 16);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].pre != PRE_NONE)
            begin
                drain();
                case (directed_rows[i].pre)
                    PRE_ZERO_QUAD: write_reg(CFG_QUAD_COEF, '0);
                    PRE_ZERO_RATE:
                    begin
                        write_reg(CFG_QUAD_COEF, QUAD_COEF_RST);
                        write_reg(CFG_PWM_RATE, '0);
                    end
                    PRE_NEG_DISC:
                    begin
                        write_reg(CFG_PWM_RATE, 48'(PWM_RATE_RST));
                        write_reg(CFG_CONST_COEF, 48'h7fffffffffff);
                    end
                    default:
                    begin
                        write_reg(CFG_SPARE, rand48());
                        load_defaults();
                    end
                endcase
            end
            send_effort(directed_rows[i].tt, directed_rows[i].r, directed_rows[i].p,
                        directed_rows[i].y, directed_rows[i].typed,
                        directed_rows[i].exp_counts);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            if (ph == 0)
                load_defaults();
            else
                random_config(ph);
            quiet = ($urandom_range(0, 3) == 0);
            // the receiver holds off while requests keep coming, filling the pipeline
            if (ph == 2)
            begin
                quiet = 1;
                long_hold = 1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_effort(rand_word(), rand_word(), rand_word(), rand_word(), 0, none);
                else
                    send_effort($signed($urandom_range(0, 40 << 16)) - (2 << 16),
                                rand_word(), rand_word(), rand_word(), 0, none);
            end
        end
        drain();
        quiet = 0;

        if (mismatches == 0 && pending_counts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qmm_pkg.sv
design/qmm_motor.sv
design/quad_motor_mixer_thrust_to_pwm.sv
sim/tb.sv
